### src/crc8r3_pkg.sv
package crc8r3_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam int         FIFO_DEPTH  = 4;
    localparam int         FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int         FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } codec_mode_t;

    typedef struct packed
    {
        logic        check_passed;
        logic        run_last;
        logic [7:0]  decoded_byte;
        logic [23:0] coded_word;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [23:0] triple_encode(input logic [7:0] data);
        logic [23:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            w[3*i +: 3] = {3{data[i]}};
        end
        return w;
    endfunction

    function automatic logic [7:0] majority_decode(input logic [23:0] word);
        logic [7:0] r;
        logic [2:0] t;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            t    = word[3*i +: 3];
            r[i] = (t[0] & t[1]) | (t[0] & t[2]) | (t[1] & t[2]);
        end
        return r;
    endfunction

endpackage

### src/crc8r3_core.sv
module crc8r3_core
    import crc8r3_pkg::*;
(
    input  codec_mode_t mode,
    input  logic [7:0]  crc,
    input  logic [7:0]  payload_byte,
    input  logic [23:0] received_word,
    input  logic        message_end,
    output result_t     first_result,
    output result_t     second_result,
    output logic [1:0]  result_count,
    output logic [7:0]  crc_next
);

    logic [7:0] enc_crc;
    logic [7:0] dec_byte;
    logic [7:0] dec_crc;

    assign enc_crc  = crc8_update(crc, payload_byte);
    assign dec_byte = majority_decode(received_word);
    assign dec_crc  = crc8_update(crc, dec_byte);

    always_comb
    begin
        first_result  = '0;
        second_result = '0;
        result_count  = 2'd1;
        crc_next      = crc;
        unique case (mode)
            MODE_ENCODE:
            begin
                first_result.coded_word = triple_encode(payload_byte);
                second_result.coded_word = triple_encode(enc_crc);
                second_result.run_last   = 1'b1;
                if (message_end)
                begin
                    result_count = 2'd2;
                    crc_next     = '0;
                end
                else
                begin
                    crc_next = enc_crc;
                end
            end
            MODE_DECODE:
            begin
                first_result.decoded_byte = dec_byte;
                first_result.run_last     = message_end;
                first_result.check_passed = message_end && (dec_crc == 8'h00);
                crc_next = message_end ? 8'h00 : dec_crc;
            end
            default:
            begin
                result_count = 2'd1;
            end
        endcase
    end

endmodule

### src/crc8r3_out_fifo.sv
module crc8r3_out_fifo
    import crc8r3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_count,
    input  result_t    push_first,
    input  result_t    push_second,
    output logic       room_for_two,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = FIFO_PTR_W'(wr_ptr_reg + FIFO_PTR_W'(push_count));
        rd_ptr_next = FIFO_PTR_W'(rd_ptr_reg + FIFO_PTR_W'(pop));
        count_next  = FIFO_CNT_W'(count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            mem[FIFO_PTR_W'(wr_ptr_reg + 1'b1)] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // no overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // pointers track the fill level
    assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == FIFO_PTR_W'(count_reg))
        else $error("queue pointers out of step with count");

endmodule

### src/crc8_repetition3_codec.sv
// a request accepted into the input stage registers is written to the output queue once the queue
// has room for two results, and its first result is then shown from the queue
// throughput: one request per cycle while the output queue has room for two results; an encode request with
// tlast adds the crc codeword as a second result, and the output queue drains one result per cycle while ready
// reset: mode returns to encode, crc clears, input stage and output queue empty
module crc8_repetition3_codec
    import crc8r3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // payload_byte[7:0], received_word[31:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // coded_word[23:0], decoded_byte[31:24]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // check_passed
);

    codec_mode_t  mode_reg;
    logic [7:0]   crc_reg;
    logic [7:0]   crc_next;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   payload_reg;
    logic [23:0]  received_reg;
    logic         end_reg;
    logic         accept;
    logic         fire;
    logic         room_for_two;
    logic [1:0]   result_count;
    logic [1:0]   push_count;
    result_t      first_result;
    result_t      second_result;
    result_t      out_data;

    assign fire          = in_valid_reg && room_for_two;
    assign s_axis_tready = !in_valid_reg || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_count    = fire ? result_count : 2'd0;
    assign in_valid_next = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    crc8r3_core u_core
    (
        .mode          (mode_reg),
        .crc           (crc_reg),
        .payload_byte  (payload_reg),
        .received_word (received_reg),
        .message_end   (end_reg),
        .first_result  (first_result),
        .second_result (second_result),
        .result_count  (result_count),
        .crc_next      (crc_next)
    );

    crc8r3_out_fifo u_out_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push_first   (first_result),
        .push_second  (second_result),
        .room_for_two (room_for_two),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (out_data)
    );

    assign m_axis_tdata = {out_data.decoded_byte, out_data.coded_word};
    assign m_axis_tlast = out_data.run_last;
    assign m_axis_tuser = out_data.check_passed;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            payload_reg  <= s_axis_tdata[7:0];
            received_reg <= s_axis_tdata[31:8];
            end_reg      <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ENCODE;
            crc_reg      <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= codec_mode_t'(cfg_wr_data);
            end
            if (fire)
            begin
                crc_reg <= crc_next;
            end
            in_valid_reg <= in_valid_next;
        end
    end

    // crc clears at the end of every message
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_reg) |=> (crc_reg == 8'h00))
        else $error("crc not cleared after message end");

    // a waiting request is never dropped while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("stalled request lost");

    // two results only for an encode request that ends a message
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd2) |-> (mode_reg == MODE_ENCODE && end_reg))
        else $error("unexpected second result");

endmodule

### sim/crc8_repetition3_codec_tb.sv
`timescale 1ns / 1ps

module crc8_repetition3_codec_tb;
    import crc8r3_pkg::*;

    typedef struct {
        logic [7:0]  payload;
        logic [23:0] rx_word;
        logic        last;
    } codec_req_t;

    typedef struct {
        logic [23:0] word;
        logic [7:0]  dec_byte;
        logic        last;
        logic        passed;
    } codec_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    codec_req_t  request_q[$];
    codec_res_t  codec_out_q[$];
    codec_mode_t model_mode = MODE_ENCODE;
    logic [7:0]  model_crc = '0;
    int          err_count = 0;
    int          stim_count = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int          tx_wait = 0;
    int          rx_wait = 0;
    bit          hold_arm = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_left = 0;

    crc8_repetition3_codec u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // serial msb-first crc, one data bit per shift
    function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [23:0] tripled(input logic [7:0] data);
        logic [23:0] w;
        w = '0;
        for (int i = 7; i >= 0; i--)
        begin
            w = {w[20:0], {3{data[i]}}};
        end
        return w;
    endfunction

    function automatic logic [7:0] vote(input logic [23:0] word);
        logic [7:0] r;
        logic [2:0] t;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            t    = 3'((word >> (3 * i)) & 24'h7);
            r[i] = ($countones(t) >= 2);
        end
        return r;
    endfunction

    // single bit errors per triple are voted away, corrupt flips two bits in one triple
    function automatic logic [23:0] noisy_word(input logic [7:0] b, input bit corrupt);
        logic [23:0] w;
        int          k;
        w = tripled(b);
        for (int i = 0; i < 8; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                w[3 * i + $urandom_range(0, 2)] ^= 1'b1;
            end
        end
        if (corrupt)
        begin
            k = $urandom_range(0, 7);
            w[3 * k +: 3] = ~{3{b[k]}} ^ (3'b001 << $urandom_range(0, 2));
        end
        return w;
    endfunction

    task automatic codec_predict(input logic [31:0] data, input logic last);
        codec_res_t res;
        logic [7:0] db;
        if (model_mode == MODE_ENCODE)
        begin
            model_crc    = crc_next(model_crc, data[7:0]);
            res.word     = tripled(data[7:0]);
            res.dec_byte = '0;
            res.last     = 1'b0;
            res.passed   = 1'b0;
            codec_out_q.push_back(res);
            if (last)
            begin
                res.word = tripled(model_crc);
                res.last = 1'b1;
                codec_out_q.push_back(res);
                model_crc = '0;
            end
        end
        else
        begin
            db           = vote(data[31:8]);
            model_crc    = crc_next(model_crc, db);
            res.word     = '0;
            res.dec_byte = db;
            res.last     = last;
            res.passed   = last && (model_crc == 8'h00);
            codec_out_q.push_back(res);
            if (last)
            begin
                model_crc = '0;
            end
        end
    endtask

    task automatic push_req(input logic [7:0] payload, input logic [23:0] word, input logic last);
        codec_req_t r;
        r.payload = payload;
        r.rx_word = word;
        r.last    = last;
        request_q.push_back(r);
        stim_count++;
    endtask

    task automatic add_encode_msg(input int n);
        for (int i = 0; i < n; i++)
        begin
            push_req(8'($urandom), 24'($urandom), i == n - 1);
        end
    endtask

    task automatic add_decode_msg(input int n, input bit corrupt);
        logic [7:0] crc;
        logic [7:0] b;
        crc = '0;
        for (int i = 0; i < n; i++)
        begin
            b   = 8'($urandom);
            crc = crc_next(crc, b);
            push_req(8'($urandom), noisy_word(b, 1'b0), 1'b0);
        end
        push_req(8'($urandom), noisy_word(crc, corrupt), 1'b1);
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || s_axis_tvalid || codec_out_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(input codec_mode_t m);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        model_mode  = m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    // request driver
    always @(posedge clk)
    begin : drive_proc
        codec_req_t r;
        bit         busy;
        if (rst_n)
        begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                codec_predict(s_axis_tdata, s_axis_tlast);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait       <= tx_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    r = request_q.pop_front();
                    s_axis_tdata  <= {r.rx_word, r.payload};
                    s_axis_tlast  <= r.last;
                    s_axis_tvalid <= 1'b1;
                    tx_wait       <= tx_calm ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= 300;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : monitor_proc
        codec_res_t e;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (codec_out_q.size() == 0)
                begin
                    $display("%0t: unexpected result tdata %h tlast %b tuser %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    err_count++;
                end
                else
                begin
                    e = codec_out_q.pop_front();
                    if (m_axis_tdata[23:0] !== e.word)
                    begin
                        $display("%0t: coded_word expected %h actual %h",
                                 $time, e.word, m_axis_tdata[23:0]);
                        err_count++;
                    end
                    if (m_axis_tdata[31:24] !== e.dec_byte)
                    begin
                        $display("%0t: decoded_byte expected %h actual %h",
                                 $time, e.dec_byte, m_axis_tdata[31:24]);
                        err_count++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, e.last, m_axis_tlast);
                        err_count++;
                    end
                    if (m_axis_tuser !== e.passed)
                    begin
                        $display("%0t: check_passed expected %b actual %b",
                                 $time, e.passed, m_axis_tuser);
                        err_count++;
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
            end
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    initial
    begin
        int m;
        int msgs;
        int sel;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // extremes in encode mode, then an open message carried into decode mode
        set_mode(MODE_ENCODE);
        push_req(8'h00, 24'hFFFFFF, 1'b0);
        push_req(8'hFF, 24'h000000, 1'b0);
        push_req(8'hA5, 24'h5A5A5A, 1'b1);
        push_req(8'h80, 24'hFFFFFF, 1'b1);
        push_req(8'h12, 24'h000000, 1'b0);
        wait_idle();
        set_mode(MODE_DECODE);
        push_req(8'hFF, 24'h000000, 1'b0);
        push_req(8'h00, 24'hFFFFFF, 1'b0);
        push_req(8'hFF, 24'h249249, 1'b0);
        push_req(8'h00, 24'hDB6DB6, 1'b1);
        add_decode_msg(2, 1'b0);
        add_decode_msg(0, 1'b0);
        add_decode_msg(3, 1'b1);
        wait_idle();

        // fill the block while the receiver holds off
        set_mode(MODE_ENCODE);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        @(posedge clk);
        hold_arm <= ~hold_arm;
        for (int i = 0; i < 12; i++)
        begin
            add_encode_msg($urandom_range(1, 6));
        end

        while (stim_count < 1600)
        begin
            wait_idle();
            m = $urandom_range(0, 1);
            set_mode(codec_mode_t'(m));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            msgs = $urandom_range(3, 20);
            for (int k = 0; k < msgs; k++)
            begin
                if (model_mode == MODE_ENCODE)
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
                    add_encode_msg(n);
                end
                else
                begin
                    sel = $urandom_range(0, 9);
                    n   = $urandom_range(0, 6);
                    if (sel < 7)
                    begin
                        add_decode_msg(n, 1'b0);
                    end
                    else if (sel < 9)
                    begin
                        add_decode_msg(n, 1'b1);
                    end
                    else
                    begin
                        push_req(8'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
                    end
                end
            end
            // leave a message open across the next mode write
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int j = 0; j < n; j++)
                begin
                    push_req(8'($urandom), 24'($urandom), 1'b0);
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (err_count == 0 && codec_out_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
